// File: design/fplw_pkg.sv
// fplw_pkg: shared types, constants and helper functions of the four-level page table walker.
// Used by fplw_front, fplw_back and four_level_page_table_walker. No dependencies.
package fplw_pkg;

  localparam int unsigned VaWidth    = 48;
  localparam int unsigned PaWidth    = 52;
  localparam int unsigned PteWidth   = 64;
  localparam int unsigned IdxWidth   = 9;
  localparam int unsigned LevelWidth = 2;

  localparam logic [LevelWidth-1:0] TopLevel  = 2'd0;
  localparam logic [LevelWidth-1:0] LastLevel = 2'd3;

  // frame mask keeps bit 11 on purpose
  localparam logic [PaWidth-1:0] FrameMask = 52'hF_FFFF_FFFF_F800;

  localparam int unsigned PresentBit = 0;
  localparam int unsigned LargeBit   = 7;
  localparam int unsigned RootBadBit = 63;

  typedef enum logic {
    ITEM_REQUEST = 1'b0,
    ITEM_ENTRY   = 1'b1
  } item_kind_e;

  typedef enum logic {
    RES_FETCH = 1'b0,
    RES_DONE  = 1'b1
  } result_kind_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BAD_ROOT    = 2'd1,
    ST_NOT_PRESENT = 2'd2,
    ST_PROTOCOL    = 2'd3
  } status_e;

  // classified input beat, as held in the queue
  typedef struct packed {
    item_kind_e           kind;
    logic [VaWidth-1:0]   vaddr;
    logic                 root_bad;
    logic [PaWidth-1:0]   root_base;
    logic                 pte_present;
    logic                 pte_large;
    logic [PaWidth-1:0]   frame;
    logic [PteWidth-1:0]  pte;
  } item_t;

  // 9-bit table index for a level
  function automatic logic [IdxWidth-1:0] level_index(
    input logic [VaWidth-1:0]    va,
    input logic [LevelWidth-1:0] lvl
  );
    logic [IdxWidth-1:0] idx;
    case (lvl)
      2'd0:    idx = va[47:39];
      2'd1:    idx = va[38:30];
      2'd2:    idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

  // page offset mask for a leaf found at a level
  function automatic logic [PaWidth-1:0] offset_mask(input logic [LevelWidth-1:0] lvl);
    logic [PaWidth-1:0] m;
    case (lvl)
      2'd0:    m = 52'h0_007F_FFFF_FFFF;
      2'd1:    m = 52'h0_0000_3FFF_FFFF;
      2'd2:    m = 52'h0_0000_001F_FFFF;
      default: m = 52'h0_0000_0000_0FFF;
    endcase
    return m;
  endfunction

  // base + index * 8, wraps at 52 bits
  function automatic logic [PaWidth-1:0] entry_address(
    input logic [PaWidth-1:0]    base,
    input logic [VaWidth-1:0]    va,
    input logic [LevelWidth-1:0] lvl
  );
    logic [PaWidth-1:0] offs;
    offs = {{(PaWidth-IdxWidth-3){1'b0}}, level_index(va, lvl), 3'b000};
    return base + offs;
  endfunction

endpackage

// File: design/fplw_front.sv
// fplw_front: accepts input beats, classifies them and holds them in a short queue.
// Depends on fplw_pkg.
module fplw_front #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               kind_i,
  input  logic [63:0]                        virtual_address_i,
  input  logic [63:0]                        root_table_i,
  input  logic [63:0]                        table_entry_i,
  output logic                               item_valid_o,
  input  logic                               item_pop_i,
  output fplw_pkg::item_t                    item_o
);

  localparam int unsigned PtrWidth = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntWidth = $clog2(QueueDepth + 1);
  localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(QueueDepth - 1);
  localparam logic [CntWidth-1:0] FullCnt = CntWidth'(QueueDepth);

  fplw_pkg::item_t             mem_q [QueueDepth];
  fplw_pkg::item_t             item_d;
  logic [PtrWidth-1:0]         wr_ptr_q, wr_ptr_d;
  logic [PtrWidth-1:0]         rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0]         count_q, count_d;
  logic                        push, pop;

  // classify
  always_comb begin
    item_d.kind        = fplw_pkg::item_kind_e'(kind_i);
    item_d.vaddr       = virtual_address_i[fplw_pkg::VaWidth-1:0];
    item_d.root_bad    = root_table_i[fplw_pkg::RootBadBit];
    item_d.root_base   = root_table_i[fplw_pkg::PaWidth-1:0];
    item_d.pte_present = table_entry_i[fplw_pkg::PresentBit];
    item_d.pte_large   = table_entry_i[fplw_pkg::LargeBit];
    item_d.frame       = table_entry_i[fplw_pkg::PaWidth-1:0] & fplw_pkg::FrameMask;
    item_d.pte         = table_entry_i;
  end

  assign in_ready_o   = (count_q < FullCnt);
  assign push         = in_valid_i && in_ready_o;
  assign item_valid_o = (count_q != '0);
  assign pop          = item_pop_i && item_valid_o;
  assign item_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_d;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("queue count beyond depth");

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> count_q == $past(count_q) + 1'b1)
    else $error("queue count missed a push");
`endif

endmodule

// File: design/fplw_back.sv
// fplw_back: walk state and result register; carries out one queued beat per cycle
// while the output register is free or draining. Depends on fplw_pkg.
module fplw_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  item_valid_i,
  output logic                  item_pop_o,
  input  fplw_pkg::item_t       item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  result_kind_o,
  output logic [51:0]           fetch_address_o,
  output logic [51:0]           physical_address_o,
  output logic [63:0]           leaf_entry_o,
  output logic [1:0]            status_o,
  output logic [1:0]            entry_level_o
);

  logic                                   busy_q, busy_d;
  logic [fplw_pkg::LevelWidth-1:0]        level_q, level_d;
  logic [fplw_pkg::VaWidth-1:0]           vaddr_q, vaddr_d;
  logic [fplw_pkg::PaWidth-1:0]           base_q, base_d;
  logic                                   out_valid_q;
  logic                                   take;
  logic [fplw_pkg::LevelWidth-1:0]        next_level;

  fplw_pkg::result_kind_e                 rkind_d, rkind_q;
  logic [fplw_pkg::PaWidth-1:0]           fetch_d, fetch_q;
  logic [fplw_pkg::PaWidth-1:0]           phys_d, phys_q;
  logic [fplw_pkg::PteWidth-1:0]          leaf_d, leaf_q;
  fplw_pkg::status_e                      status_d, status_q;
  logic [fplw_pkg::LevelWidth-1:0]        plevel_d, plevel_q;

  assign take       = item_valid_i && (!out_valid_q || out_ready_i);
  assign item_pop_o = take;
  assign next_level = level_q + 1'b1;

  always_comb begin
    busy_d   = busy_q;
    level_d  = level_q;
    vaddr_d  = vaddr_q;
    base_d   = base_q;
    rkind_d  = fplw_pkg::RES_DONE;
    fetch_d  = '0;
    phys_d   = '0;
    leaf_d   = '0;
    status_d = fplw_pkg::ST_OK;
    plevel_d = level_q;
    if (item_i.kind == fplw_pkg::ITEM_REQUEST) begin
      if (busy_q) begin
        status_d = fplw_pkg::ST_PROTOCOL;
      end else if (item_i.root_bad) begin
        status_d = fplw_pkg::ST_BAD_ROOT;
        plevel_d = fplw_pkg::TopLevel;
      end else begin
        busy_d   = 1'b1;
        level_d  = fplw_pkg::TopLevel;
        vaddr_d  = item_i.vaddr;
        base_d   = item_i.root_base;
        rkind_d  = fplw_pkg::RES_FETCH;
        fetch_d  = fplw_pkg::entry_address(item_i.root_base, item_i.vaddr,
                                           fplw_pkg::TopLevel);
        plevel_d = fplw_pkg::TopLevel;
      end
    end else begin
      if (!busy_q) begin
        status_d = fplw_pkg::ST_PROTOCOL;
      end else if (!item_i.pte_present) begin
        status_d = fplw_pkg::ST_NOT_PRESENT;
        busy_d   = 1'b0;
        level_d  = fplw_pkg::TopLevel;
      end else if (level_q == fplw_pkg::LastLevel || item_i.pte_large) begin
        phys_d  = item_i.frame |
                  ({{(fplw_pkg::PaWidth-fplw_pkg::VaWidth){1'b0}}, vaddr_q} &
                   fplw_pkg::offset_mask(level_q));
        leaf_d  = item_i.pte;
        busy_d  = 1'b0;
        level_d = fplw_pkg::TopLevel;
      end else begin
        level_d  = next_level;
        base_d   = item_i.frame;
        rkind_d  = fplw_pkg::RES_FETCH;
        fetch_d  = fplw_pkg::entry_address(item_i.frame, vaddr_q, next_level);
        plevel_d = next_level;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      level_q     <= '0;
      vaddr_q     <= '0;
      base_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        busy_q  <= busy_d;
        level_q <= level_d;
        vaddr_q <= vaddr_d;
        base_q  <= base_d;
      end
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      rkind_q  <= rkind_d;
      fetch_q  <= fetch_d;
      phys_q   <= phys_d;
      leaf_q   <= leaf_d;
      status_q <= status_d;
      plevel_q <= plevel_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign result_kind_o      = rkind_q;
  assign fetch_address_o    = fetch_q;
  assign physical_address_o = phys_q;
  assign leaf_entry_o       = leaf_q;
  assign status_o           = status_q;
  assign entry_level_o      = plevel_q;

`ifndef ASSERT_OFF
  a_idle_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> level_q == fplw_pkg::TopLevel)
    else $error("idle walker with nonzero level");

  a_fetch_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && rkind_d == fplw_pkg::RES_FETCH) |=> busy_q)
    else $error("fetch issued but walker not busy");

  a_fault_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && (status_d == fplw_pkg::ST_BAD_ROOT || status_d == fplw_pkg::ST_NOT_PRESENT))
      |=> !busy_q)
    else $error("fault left walker busy");

  a_level_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && item_i.kind == fplw_pkg::ITEM_ENTRY && rkind_d == fplw_pkg::RES_FETCH)
      |=> level_q == $past(next_level))
    else $error("level did not advance on descent");
`endif

endmodule

// File: design/four_level_page_table_walker.sv
// four_level_page_table_walker: top level, front queue feeding the walk back end.
// Depends on fplw_pkg, fplw_front and fplw_back.

// Four-level page table walker, one table level per input beat. A request beat
// (kind 0) starts a walk and is answered with a fetch of the top-level entry at
// root + index*8; each entry beat (kind 1) returned from memory is checked and
// answered with either the next fetch or a finished result (physical address and
// raw leaf entry, or a fault status). Every input beat gives exactly one result
// beat, in order. The front end classifies beats into a QueueDepth-entry queue
// and the back end applies one queued beat per cycle to the walk state while the
// output register is free or being drained, writing the result into that register.
// Throughput is one beat per cycle when the output side keeps up; an accepted
// beat is written into the queue and from there into the output register. Input
// ready drops only when the queue is full. A request during a walk, or an entry
// with no walk in progress, gets a protocol-error result and leaves the walk
// untouched. Root bit 63 set faults at once.
module four_level_page_table_walker #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic         kind_i,
  input  logic [63:0]  virtual_address_i,
  input  logic [63:0]  root_table_i,
  input  logic [63:0]  table_entry_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic         result_kind_o,
  output logic [51:0]  fetch_address_o,
  output logic [51:0]  physical_address_o,
  output logic [63:0]  leaf_entry_o,
  output logic [1:0]   status_o,
  output logic [1:0]   entry_level_o
);

  // queue head into the back end
  logic            item_valid;
  logic            item_pop;
  fplw_pkg::item_t item;

  fplw_front #(
    .QueueDepth (QueueDepth)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .kind_i            (kind_i),
    .virtual_address_i (virtual_address_i),
    .root_table_i      (root_table_i),
    .table_entry_i     (table_entry_i),
    .item_valid_o      (item_valid),
    .item_pop_i        (item_pop),
    .item_o            (item)
  );

  // back end pops when its output register is free or being drained
  fplw_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .item_valid_i       (item_valid),
    .item_pop_o         (item_pop),
    .item_i             (item),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .result_kind_o      (result_kind_o),
    .fetch_address_o    (fetch_address_o),
    .physical_address_o (physical_address_o),
    .leaf_entry_o       (leaf_entry_o),
    .status_o           (status_o),
    .entry_level_o      (entry_level_o)
  );

endmodule

// File: test/four_level_page_table_walker_tb.sv
// four_level_page_table_walker_tb: self-checking bench for the page table walker.
// A directed table is followed by random walks, and every result beat is checked against
// a typed expectation or the in-bench walk predictor. Depends on fplw_pkg and the walker RTL.
module four_level_page_table_walker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomBeats   = 400;
  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = 10;

  // One result beat as the walker should present it.
  typedef struct {
    fplw_pkg::result_kind_e rkind;
    logic [51:0]            fetch;
    logic [51:0]            phys;
    logic [63:0]            leaf;
    fplw_pkg::status_e      status;
    logic [1:0]             level;
  } walk_result_t;

  // One input beat, plus an optional hand-written expectation.
  typedef struct {
    fplw_pkg::item_kind_e   kind;
    logic [63:0]            va;
    logic [63:0]            root;
    logic [63:0]            pte;
    bit                     typed;
    walk_result_t           res;
  } stim_row_t;

  logic         clk_i;
  logic         rst_ni             = 1'b0;
  logic         in_valid_i         = 1'b0;
  logic         in_ready_o;
  logic         kind_i             = 1'b0;
  logic [63:0]  virtual_address_i  = '0;
  logic [63:0]  root_table_i       = '0;
  logic [63:0]  table_entry_i      = '0;
  logic         out_valid_o;
  logic         out_ready_i        = 1'b0;
  logic         result_kind_o;
  logic [51:0]  fetch_address_o;
  logic [51:0]  physical_address_o;
  logic [63:0]  leaf_entry_o;
  logic [1:0]   status_o;
  logic [1:0]   entry_level_o;

  four_level_page_table_walker DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .kind_i             (kind_i),
    .virtual_address_i  (virtual_address_i),
    .root_table_i       (root_table_i),
    .table_entry_i      (table_entry_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .result_kind_o      (result_kind_o),
    .fetch_address_o    (fetch_address_o),
    .physical_address_o (physical_address_o),
    .leaf_entry_o       (leaf_entry_o),
    .status_o           (status_o),
    .entry_level_o      (entry_level_o)
  );

  // Predicted walk state, updated when an input beat is accepted.
  logic         walk_active;
  logic [1:0]   walk_level;
  logic [47:0]  walk_va;
  logic [51:0]  walk_base;

  walk_result_t results_due_q[$];
  stim_row_t    walk_table[$];
  int           beats_sent;
  int           mismatch_count;
  int           quiet_cycles;
  bit           steady;          // no idling on either side while set

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Entry address for a level: table base plus 9-bit VA slice times 8, 52-bit wrap.
  function automatic logic [51:0] walk_fetch_addr(logic [51:0] base, logic [47:0] va,
                                                   logic [1:0] lvl);
    logic [8:0] idx;
    idx = 9'(va >> (39 - 9 * int'(lvl)));
    return base + {40'b0, idx, 3'b000};
  endfunction

  // Page offset bits kept from the VA for a leaf at this level.
  function automatic logic [51:0] leaf_offset_mask(logic [1:0] lvl);
    return (52'd1 << (39 - 9 * int'(lvl))) - 52'd1;
  endfunction

  // Apply one accepted beat to the predicted walk state, return its result.
  function automatic walk_result_t walk_predict(stim_row_t row);
    walk_result_t r;
    logic [51:0]  frame;
    r.rkind  = fplw_pkg::RES_DONE;
    r.fetch  = '0;
    r.phys   = '0;
    r.leaf   = '0;
    r.status = fplw_pkg::ST_OK;
    r.level  = fplw_pkg::TopLevel;
    if (row.kind == fplw_pkg::ITEM_REQUEST) begin
      if (walk_active) begin
        // walk in progress stays untouched
        r.status = fplw_pkg::ST_PROTOCOL;
        r.level  = walk_level;
      end else if (row.root[fplw_pkg::RootBadBit]) begin
        r.status = fplw_pkg::ST_BAD_ROOT;
      end else begin
        walk_va     = row.va[47:0];
        walk_base   = row.root[51:0];
        walk_level  = fplw_pkg::TopLevel;
        walk_active = 1'b1;
        r.rkind     = fplw_pkg::RES_FETCH;
        r.fetch     = walk_fetch_addr(walk_base, walk_va, fplw_pkg::TopLevel);
      end
    end else begin
      frame = row.pte[51:0] & fplw_pkg::FrameMask;
      r.level = walk_level;
      if (!walk_active) begin
        r.status = fplw_pkg::ST_PROTOCOL;
      end else if (!row.pte[fplw_pkg::PresentBit]) begin
        r.status    = fplw_pkg::ST_NOT_PRESENT;
        walk_active = 1'b0;
        walk_level  = fplw_pkg::TopLevel;
      end else if (walk_level == fplw_pkg::LastLevel || row.pte[fplw_pkg::LargeBit]) begin
        r.phys      = frame | (52'(walk_va) & leaf_offset_mask(walk_level));
        r.leaf      = row.pte;
        walk_active = 1'b0;
        walk_level  = fplw_pkg::TopLevel;
      end else begin
        walk_level = walk_level + 2'd1;
        walk_base  = frame;
        r.rkind    = fplw_pkg::RES_FETCH;
        r.fetch    = walk_fetch_addr(frame, walk_va, walk_level);
        r.level    = walk_level;
      end
    end
    return r;
  endfunction

  function automatic void add_row(fplw_pkg::item_kind_e kind, logic [63:0] va,
                                  logic [63:0] root, logic [63:0] pte, bit typed,
                                  fplw_pkg::result_kind_e rk, logic [51:0] fetch,
                                  fplw_pkg::status_e st, logic [1:0] lvl);
    stim_row_t row;
    row.kind       = kind;
    row.va         = va;
    row.root       = root;
    row.pte        = pte;
    row.typed      = typed;
    row.res.rkind  = rk;
    row.res.fetch  = fetch;
    row.res.phys   = '0;
    row.res.leaf   = '0;
    row.res.status = st;
    row.res.level  = lvl;
    walk_table.push_back(row);
  endfunction

  // Present one beat at a falling edge, after random idling unless steady; hold until accepted.
  // The prediction is taken at the accepting edge, in acceptance order.
  task automatic send_beat(stim_row_t row);
    walk_result_t predicted;
    @(negedge clk_i);
    while (!steady && $urandom_range(99) < 10) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i        <= 1'b1;
    kind_i            <= row.kind;
    virtual_address_i <= row.va;
    root_table_i      <= row.root;
    table_entry_i     <= row.pte;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = walk_predict(row);
    results_due_q.push_back(row.typed ? row.res : predicted);
    beats_sent++;
  endtask

  // Drop valid and hold off until every outstanding result beat is back.
  task automatic wait_for_drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (results_due_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic void check_field(string name, logic [63:0] exp, logic [63:0] act);
    if (act !== exp) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
      mismatch_count++;
    end
  endfunction

  // Receiver: drops ready at random about a tenth of the time, except during the steady stretch.
  always @(negedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(99) >= 10);
  end

  // Result checker: every result beat against the oldest expectation.
  always @(posedge clk_i) begin
    walk_result_t exp;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (results_due_q.size() == 0) begin
        $error("result beat with no expectation pending");
        mismatch_count++;
      end else begin
        exp = results_due_q.pop_front();
        check_field("result_kind", 64'(exp.rkind), 64'(result_kind_o));
        check_field("fetch_address", 64'(exp.fetch), 64'(fetch_address_o));
        check_field("physical_address", 64'(exp.phys), 64'(physical_address_o));
        check_field("leaf_entry", exp.leaf, leaf_entry_o);
        check_field("status", 64'(exp.status), 64'(status_o));
        check_field("entry_level", 64'(exp.level), 64'(entry_level_o));
      end
    end
  end

  // Watchdog: too long without a beat on either side ends the run.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    stim_row_t row;
    int        target;
    walk_active    = 1'b0;
    walk_level     = fplw_pkg::TopLevel;
    walk_va        = '0;
    walk_base      = '0;
    beats_sent     = 0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    steady         = 1'b0;

    // Directed table. Faults and protocol errors have their expectation typed
    // in; leaves and fetches with real address math go through the predictor.
    // entry with no walk, straight out of reset
    add_row(fplw_pkg::ITEM_ENTRY, '0, '0, '1, 1'b1, fplw_pkg::RES_DONE, '0,
            fplw_pkg::ST_PROTOCOL, 2'd0);
    // invalid root faults at once
    add_row(fplw_pkg::ITEM_REQUEST, '1, 64'h8000_0000_0000_0000, '0, 1'b1,
            fplw_pkg::RES_DONE, '0, fplw_pkg::ST_BAD_ROOT, 2'd0);
    add_row(fplw_pkg::ITEM_REQUEST, '0, '0, '0, 1'b1, fplw_pkg::RES_FETCH, '0,
            fplw_pkg::ST_OK, 2'd0);
    // request while a walk is open
    add_row(fplw_pkg::ITEM_REQUEST, '1, '1, '0, 1'b1, fplw_pkg::RES_DONE, '0,
            fplw_pkg::ST_PROTOCOL, 2'd0);
    add_row(fplw_pkg::ITEM_ENTRY, '0, '0, '0, 1'b1, fplw_pkg::RES_DONE, '0,
            fplw_pkg::ST_NOT_PRESENT, 2'd0);
    add_row(fplw_pkg::ITEM_ENTRY, '1, '1, '0, 1'b1, fplw_pkg::RES_DONE, '0,
            fplw_pkg::ST_PROTOCOL, 2'd0);
    // root bits 62:52 ignored, base + index*8 wraps at 52 bits
    add_row(fplw_pkg::ITEM_REQUEST, '1, 64'h7FFF_FFFF_FFFF_FFFF, '0, 1'b0,
            fplw_pkg::RES_DONE, '0, fplw_pkg::ST_OK, 2'd0);
    // large page at the top level: 512 GiB leaf
    add_row(fplw_pkg::ITEM_ENTRY, '0, '0, '1, 1'b0, fplw_pkg::RES_DONE, '0,
            fplw_pkg::ST_OK, 2'd0);
    // full four-level walk; bit 11 of the frame survives the mask
    add_row(fplw_pkg::ITEM_REQUEST, 64'hFFFF_8123_4567_89AB, 64'h000F_FFFF_FFFF_F000, '0,
            1'b0, fplw_pkg::RES_DONE, '0, fplw_pkg::ST_OK, 2'd0);
    add_row(fplw_pkg::ITEM_ENTRY, '0, '0, 64'h0000_0000_0000_0801, 1'b0,
            fplw_pkg::RES_DONE, '0, fplw_pkg::ST_OK, 2'd0);
    add_row(fplw_pkg::ITEM_REQUEST, '0, '0, '0, 1'b1, fplw_pkg::RES_DONE, '0,
            fplw_pkg::ST_PROTOCOL, 2'd1);
    add_row(fplw_pkg::ITEM_ENTRY, '0, '0, 64'h8000_0000_0000_0003, 1'b0,
            fplw_pkg::RES_DONE, '0, fplw_pkg::ST_OK, 2'd0);
    add_row(fplw_pkg::ITEM_ENTRY, '0, '0, 64'h7FF0_0000_1234_5001, 1'b0,
            fplw_pkg::RES_DONE, '0, fplw_pkg::ST_OK, 2'd0);
    add_row(fplw_pkg::ITEM_REQUEST, '1, '0, '0, 1'b1, fplw_pkg::RES_DONE, '0,
            fplw_pkg::ST_PROTOCOL, 2'd3);
    add_row(fplw_pkg::ITEM_ENTRY, '0, '0, 64'hFFFF_FFFF_FFFF_FF7F, 1'b0,
            fplw_pkg::RES_DONE, '0, fplw_pkg::ST_OK, 2'd0);
    // 1 GiB leaf
    add_row(fplw_pkg::ITEM_REQUEST, 64'h0000_5555_5555_5555, 64'h0000_AAAA_AAAA_A000, '0,
            1'b0, fplw_pkg::RES_DONE, '0, fplw_pkg::ST_OK, 2'd0);
    add_row(fplw_pkg::ITEM_ENTRY, '0, '0, 64'h0000_0000_4000_0001, 1'b0,
            fplw_pkg::RES_DONE, '0, fplw_pkg::ST_OK, 2'd0);
    add_row(fplw_pkg::ITEM_ENTRY, '0, '0, 64'h0000_000F_C000_0081, 1'b0,
            fplw_pkg::RES_DONE, '0, fplw_pkg::ST_OK, 2'd0);
    // 2 MiB leaf
    add_row(fplw_pkg::ITEM_REQUEST, 64'h0000_AAAA_AAAA_AAAA, 64'h0000_1234_5678_9000, '0,
            1'b0, fplw_pkg::RES_DONE, '0, fplw_pkg::ST_OK, 2'd0);
    add_row(fplw_pkg::ITEM_ENTRY, '0, '0, 64'h0000_0003_0000_0001, 1'b0,
            fplw_pkg::RES_DONE, '0, fplw_pkg::ST_OK, 2'd0);
    add_row(fplw_pkg::ITEM_ENTRY, '0, '0, 64'h0000_0000_0020_0001, 1'b0,
            fplw_pkg::RES_DONE, '0, fplw_pkg::ST_OK, 2'd0);
    add_row(fplw_pkg::ITEM_ENTRY, '0, '0, 64'h000F_FFFF_FFE0_0883, 1'b0,
            fplw_pkg::RES_DONE, '0, fplw_pkg::ST_OK, 2'd0);
    // not present at the last level
    add_row(fplw_pkg::ITEM_REQUEST, 64'h0000_0123_4567_8000, 64'h0000_0000_0000_1000, '0,
            1'b0, fplw_pkg::RES_DONE, '0, fplw_pkg::ST_OK, 2'd0);
    add_row(fplw_pkg::ITEM_ENTRY, '0, '0, 64'h0000_0000_0000_2001, 1'b0,
            fplw_pkg::RES_DONE, '0, fplw_pkg::ST_OK, 2'd0);
    add_row(fplw_pkg::ITEM_ENTRY, '0, '0, 64'h0000_0000_0000_3001, 1'b0,
            fplw_pkg::RES_DONE, '0, fplw_pkg::ST_OK, 2'd0);
    add_row(fplw_pkg::ITEM_ENTRY, '0, '0, 64'h0000_0000_0000_4001, 1'b0,
            fplw_pkg::RES_DONE, '0, fplw_pkg::ST_OK, 2'd0);
    add_row(fplw_pkg::ITEM_ENTRY, '0, '0, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1,
            fplw_pkg::RES_DONE, '0, fplw_pkg::ST_NOT_PRESENT, 2'd3);

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (walk_table[i]) send_beat(walk_table[i]);

    // Hold the sender until the directed part has fully drained.
    wait_for_drain();

    // Random part: mostly well-formed walks with random content, some noise.
    // A stretch in the middle runs with no idling on either side.
    target = beats_sent + RandomBeats;
    while (beats_sent < target) begin
      steady = (beats_sent >= target - 250) && (beats_sent < target - 150);
      row.typed = 1'b0;
      row.res   = results_due_q.size() != 0 ? results_due_q[0] : row.res;
      row.va    = {$urandom, $urandom};
      row.root  = {$urandom, $urandom};
      row.pte   = {$urandom, $urandom};
      if ($urandom_range(99) < 6) begin
        // noise: protocol errors and stray beats
        row.kind = fplw_pkg::item_kind_e'($urandom_range(1));
      end else if (!walk_active) begin
        row.kind = fplw_pkg::ITEM_REQUEST;
        row.root[fplw_pkg::RootBadBit] = ($urandom_range(99) < 5);
      end else begin
        row.kind = fplw_pkg::ITEM_ENTRY;
        row.pte[fplw_pkg::PresentBit] = ($urandom_range(99) >= 8);
        row.pte[fplw_pkg::LargeBit]   = ($urandom_range(99) < 20);
      end
      send_beat(row);
      if ($urandom_range(99) == 0) wait_for_drain();
    end
    steady = 1'b0;

    wait_for_drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && results_due_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
